// ===== sv/periodic_ghost_image_generator_core_assert.svh =====
// assertion macros for the periodic ghost image generator
// expects i_clk and i_rst_n in the including scope
`ifndef PERIODIC_GHOST_IMAGE_GENERATOR_CORE_ASSERT_SVH
`define PERIODIC_GHOST_IMAGE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PGIG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pgig assertion failed");

// next-cycle implication
`define PGIG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pgig assertion failed");

`endif

// ===== sv/pgig_pkg.sv =====
// shared types and constants of the periodic ghost image generator
// no dependencies
package pgig_pkg;

    localparam int K_NUM_COMBO = 7;
    localparam int K_FLAG_W    = 6;

    // axis sets in emission order: x, y, z, xy, xz, yz, xyz
    localparam logic [2:0] K_COMBO [K_NUM_COMBO] = '{
        3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
    };

    // configuration register indexes
    localparam logic [2:0] REG_BOX_LOW_X  = 3'd0;
    localparam logic [2:0] REG_BOX_LOW_Y  = 3'd1;
    localparam logic [2:0] REG_BOX_LOW_Z  = 3'd2;
    localparam logic [2:0] REG_BOX_HIGH_X = 3'd3;
    localparam logic [2:0] REG_BOX_HIGH_Y = 3'd4;
    localparam logic [2:0] REG_BOX_HIGH_Z = 3'd5;
    localparam logic [2:0] REG_MARGIN     = 3'd6;
    localparam logic [2:0] REG_MODE       = 3'd7;

    localparam logic [3:0] MODE_RESET   = 4'd7;
    localparam int         MODE_VEL_BIT = 3;

    typedef struct packed {
        logic [2:0] hi;
        logic [2:0] lo;
    } t_face_flags;

    typedef struct packed {
        logic busy;
        logic rem_empty;
        logic emit_last;
    } t_back_status;

endpackage

// ===== sv/periodic_ghost_image_generator_core.sv =====
// periodic ghost image generator, top level: config registers, front, queue, back
// a queued atom passes the queue, the back's atom registers and the output register
// throughput: one atom per cycle while the queue has room; the back emits one ghost
// word per cycle unless the output stalls, and the 2-entry queue absorbs the front meanwhile
// reset (synchronous, active low) empties the queue and output, restores config
// depends on pgig_pkg, pgig_front, pgig_queue, pgig_back and the assert header
`include "periodic_ghost_image_generator_core_assert.svh"

module periodic_ghost_image_generator_core #(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH    = 32,
    parameter int KIND_WIDTH  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, atom_id, atom_kind, zero pad
    input  logic [((6*COORD_WIDTH+ID_WIDTH+KIND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // img_x, img_y, img_z, img_vel_x, img_vel_y, img_vel_z, img_id, img_kind, zero pad
    output logic [((6*COORD_WIDTH+ID_WIDTH+KIND_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);
    import pgig_pkg::*;

    localparam int FIELD_W = 6*COORD_WIDTH + ID_WIDTH + KIND_WIDTH;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
    localparam int ENTRY_W = FIELD_W + K_FLAG_W;
    localparam int Q_DEPTH = 2;

    logic [2:0][COORD_WIDTH-1:0] r_box_lo, r_box_hi;
    logic [COORD_WIDTH-2:0]      r_margin;
    logic [3:0]                  r_mode;

    logic               q_ready, q_push, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_in, q_out;
    t_back_status       back_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_lo <= '0;
            r_box_hi <= '0;
            r_margin <= '0;
            r_mode   <= MODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_LOW_X:  r_box_lo[0] <= i_cfg_data;
                REG_BOX_LOW_Y:  r_box_lo[1] <= i_cfg_data;
                REG_BOX_LOW_Z:  r_box_lo[2] <= i_cfg_data;
                REG_BOX_HIGH_X: r_box_hi[0] <= i_cfg_data;
                REG_BOX_HIGH_Y: r_box_hi[1] <= i_cfg_data;
                REG_BOX_HIGH_Z: r_box_hi[2] <= i_cfg_data;
                REG_MARGIN:     r_margin    <= i_cfg_data[COORD_WIDTH-2:0];
                REG_MODE:       r_mode      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    pgig_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FIELD_W     (FIELD_W)
    ) u_front (
        .i_pos_valid (s_axis_tvalid),
        .i_fields    (s_axis_tdata[FIELD_W-1:0]),
        .i_box_lo    (r_box_lo),
        .i_box_hi    (r_box_hi),
        .i_margin    (r_margin),
        .i_mode      (r_mode),
        .i_q_ready   (q_ready),
        .o_ready     (s_axis_tready),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    pgig_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    pgig_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .ID_WIDTH    (ID_WIDTH),
        .KIND_WIDTH  (KIND_WIDTH),
        .FIELD_W     (FIELD_W),
        .TDATA_W     (TDATA_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .i_box_lo  (r_box_lo),
        .i_box_hi  (r_box_hi),
        .i_mode    (r_mode),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast),
        .o_status  (back_status)
    );

    // only accepted words with a flagged face reach the queue
    `PGIG_ASSERT_NOW(a_push_on_accept, q_push, s_axis_tvalid && s_axis_tready)
    // a busy back always has an axis set left to emit
    `PGIG_ASSERT_NOW(a_busy_has_work, back_status.busy, !back_status.rem_empty)
    // after the final ghost the back idles unless a queued atom was waiting
    `PGIG_ASSERT_NEXT(a_last_frees_back, back_status.emit_last,
        !back_status.busy || $past(q_valid))
endmodule

// ===== sv/pgig_queue.sv =====
// small register fifo between front and back
// uses no package
module pgig_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== sv/pgig_front.sv =====
// front: takes atoms, tests them against the box faces, queues edge atoms
// depends on pgig_pkg
module pgig_front #(
    parameter int COORD_WIDTH = 32,
    parameter int FIELD_W     = 232
) (
    input  logic                               i_pos_valid,
    input  logic [FIELD_W-1:0]                 i_fields,
    input  logic [2:0][COORD_WIDTH-1:0]        i_box_lo,
    input  logic [2:0][COORD_WIDTH-1:0]        i_box_hi,
    input  logic [COORD_WIDTH-2:0]             i_margin,
    input  logic [3:0]                         i_mode,
    input  logic                               i_q_ready,
    output logic                               o_ready,
    output logic                               o_push,
    output logic [FIELD_W+pgig_pkg::K_FLAG_W-1:0] o_entry
);
    import pgig_pkg::*;

    localparam int EW = COORD_WIDTH + 1;

    logic signed [EW-1:0] p [3];
    logic signed [EW-1:0] lo_m [3];
    logic signed [EW-1:0] hi_m [3];
    logic signed [EW-1:0] m;
    t_face_flags          flags;

    assign m = EW'({2'b00, i_margin});

    always_comb begin
        flags = '0;
        for (int a = 0; a < 3; a++) begin
            p[a] = {i_fields[a*COORD_WIDTH+COORD_WIDTH-1], i_fields[a*COORD_WIDTH +: COORD_WIDTH]};
            lo_m[a] = {i_box_lo[a][COORD_WIDTH-1], i_box_lo[a]} + m;
            hi_m[a] = {i_box_hi[a][COORD_WIDTH-1], i_box_hi[a]} - m;
            if (i_mode[a]) begin
                // low face wins when both are near
                if (p[a] < lo_m[a]) begin
                    flags.lo[a] = 1'b1;
                end else if (p[a] > hi_m[a]) begin
                    flags.hi[a] = 1'b1;
                end
            end
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_pos_valid && i_q_ready && ((flags.lo | flags.hi) != 3'b000);
    assign o_entry = {flags, i_fields};
endmodule

// ===== sv/pgig_back.sv =====
// back: walks the axis sets of one queued atom and emits one ghost word a cycle unless the output stalls
// depends on pgig_pkg
module pgig_back #(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH    = 32,
    parameter int KIND_WIDTH  = 8,
    parameter int FIELD_W     = 232,
    parameter int TDATA_W     = 232
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  logic [FIELD_W+pgig_pkg::K_FLAG_W-1:0] i_q_entry,
    output logic                                  o_q_pop,
    input  logic [2:0][COORD_WIDTH-1:0]           i_box_lo,
    input  logic [2:0][COORD_WIDTH-1:0]           i_box_hi,
    input  logic [3:0]                            i_mode,
    output logic                                  o_tvalid,
    input  logic                                  i_tready,
    output logic [TDATA_W-1:0]                    o_tdata,
    output logic                                  o_tlast,
    output pgig_pkg::t_back_status                o_status
);
    import pgig_pkg::*;

    localparam int C = COORD_WIDTH;

    logic [2:0][C-1:0]          r_width;
    logic [2:0][C-1:0]          r_pos;
    logic [2:0][C-1:0]          r_vel;
    logic [ID_WIDTH-1:0]        r_id;
    logic [KIND_WIDTH-1:0]      r_kind;
    logic [2:0]                 r_hi;
    logic [K_NUM_COMBO-1:0]     r_rem, n_rem, load_rem;
    logic                       r_busy;
    logic                       r_out_valid;
    logic [TDATA_W-1:0]         r_out_data;
    logic                       r_out_last;
    logic [FIELD_W-1:0]         n_out_data;
    logic [2:0]                 sel;
    logic [2:0]                 combo;
    logic                       last, emit, load;
    t_face_flags                q_flags;
    logic [2:0]                 q_active;

    assign q_flags  = i_q_entry[FIELD_W +: K_FLAG_W];
    assign q_active = q_flags.lo | q_flags.hi;

    always_comb begin
        for (int k = 0; k < K_NUM_COMBO; k++) begin
            load_rem[k] = ((K_COMBO[k] & q_active) == K_COMBO[k]);
        end
    end

    // lowest pending axis set
    always_comb begin
        sel = '0;
        for (int k = K_NUM_COMBO - 1; k >= 0; k--) begin
            if (r_rem[k]) begin
                sel = 3'(k);
            end
        end
    end

    assign combo = K_COMBO[sel];
    assign n_rem = r_rem & ~(K_NUM_COMBO'(1) << sel);
    assign last  = (n_rem == '0);
    assign emit  = r_busy && (!r_out_valid || i_tready);
    assign load  = i_q_valid && (!r_busy || (emit && last));

    always_comb begin
        n_out_data = '0;
        for (int a = 0; a < 3; a++) begin
            if (combo[a]) begin
                n_out_data[a*C +: C] = r_hi[a] ? r_pos[a] - r_width[a] : r_pos[a] + r_width[a];
            end else begin
                n_out_data[a*C +: C] = r_pos[a];
            end
            n_out_data[(3+a)*C +: C] = i_mode[MODE_VEL_BIT] ? r_vel[a] : '0;
        end
        n_out_data[6*C +: ID_WIDTH]            = r_id;
        n_out_data[6*C+ID_WIDTH +: KIND_WIDTH] = r_kind;
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_width[a] <= i_box_hi[a] - i_box_lo[a];
        end
        if (load) begin
            for (int a = 0; a < 3; a++) begin
                r_pos[a] <= i_q_entry[a*C +: C];
                r_vel[a] <= i_q_entry[(3+a)*C +: C];
            end
            r_id   <= i_q_entry[6*C +: ID_WIDTH];
            r_kind <= i_q_entry[6*C+ID_WIDTH +: KIND_WIDTH];
            r_hi   <= q_flags.hi;
        end
        if (emit) begin
            r_out_data <= TDATA_W'(n_out_data);
            r_out_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_rem  <= load_rem;
            end else if (emit && last) begin
                r_busy <= 1'b0;
                r_rem  <= '0;
            end else if (emit) begin
                r_rem <= n_rem;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_q_pop            = load;
    assign o_tvalid           = r_out_valid;
    assign o_tdata            = r_out_data;
    assign o_tlast            = r_out_last;
    assign o_status.busy      = r_busy;
    assign o_status.rem_empty = (r_rem == '0);
    assign o_status.emit_last = emit && last;
endmodule
